@@ hw/rtl/response_pattern_watcher_core_assert.svh @@
// Assertion helpers shared by the watcher RTL.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef RESPONSE_PATTERN_WATCHER_CORE_ASSERT_SVH
`define RESPONSE_PATTERN_WATCHER_CORE_ASSERT_SVH

// Same-cycle implication.
`define RPW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RPW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rpw_pkg.sv @@
package rpw_pkg;

    // Request kinds on the input channel
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_MATCH   = 2'd1,
        PH_CAPTURE = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        CAUSE_RUN     = 3'd0,
        CAUSE_MATCHED = 3'd1,
        CAUSE_ERROR   = 3'd2,
        CAUSE_TIMEOUT = 3'd3,
        CAUSE_FULL    = 3'd4
    } cause_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_PATTERN_BYTES  = 2'd0;
    localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd2;
    localparam logic [1:0] CFG_CAPTURE_LENGTH = 2'd3;

    localparam int unsigned PATTERN_W     = 64;
    localparam int unsigned PATTERN_SLOTS = 8;
    localparam int unsigned PLEN_W        = 4;
    localparam int unsigned TIMEOUT_W     = 32;
    localparam int unsigned CAPLEN_W      = 11;
    localparam int unsigned CFG_DATA_W    = 64;
    localparam int unsigned CAPLEN_MAX    = 2047;

    localparam logic [PATTERN_W-1:0] PATTERN_RESET = 64'h0000_0000_003D_4B4F;
    localparam logic [PLEN_W-1:0]    PLEN_RESET    = 4'd3;

    localparam int unsigned ERR_LEN = 5;
    localparam logic [7:0] ERR_TEXT [ERR_LEN] = '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};

    typedef struct packed {
        logic matched;
        logic errored;
    } track_t;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [9:0]  data_index;
        logic        done_res;
        logic [10:0] result_value;
        cause_t      end_cause;
    } result_t;

endpackage

@@ hw/rtl/rpw_tracker.sv @@
module rpw_tracker #(
    parameter int unsigned MAX_PATTERN = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  rpw_pkg::cmd_t                     cmd,
    input  logic [7:0]                        rx_byte,
    input  rpw_pkg::phase_t                   phase,
    input  logic [rpw_pkg::PATTERN_W-1:0]     pattern_bytes,
    input  logic [rpw_pkg::PLEN_W-1:0]        pattern_length,
    output rpw_pkg::track_t                   track
);
    import rpw_pkg::*;

    localparam int unsigned PAT_LIM = (MAX_PATTERN < PATTERN_SLOTS) ? MAX_PATTERN
                                                                    : PATTERN_SLOTS;
    localparam int unsigned MPW = $clog2(PAT_LIM + 1);

    logic [MPW-1:0] mp_reg, mp_next;
    logic [2:0]     ep_reg, ep_next;
    logic [MPW:0]   mp_sum;
    logic [3:0]     mp_wide;
    logic [7:0]     pat_cur;
    logic [7:0]     pat_arr [PATTERN_SLOTS];
    logic [PLEN_W-1:0] eff_len;
    logic [2:0]     ep_idx;
    logic [3:0]     ep_sum;

    always_comb
    begin
        for (int k = 0; k < PATTERN_SLOTS; k++)
        begin
            pat_arr[k] = pattern_bytes[8*k +: 8];
        end
    end

    // Clamp the pattern length to 1..PAT_LIM
    always_comb
    begin
        if (pattern_length == '0)
            eff_len = PLEN_W'(1);
        else if (pattern_length > PLEN_W'(PAT_LIM))
            eff_len = PLEN_W'(PAT_LIM);
        else
            eff_len = pattern_length;
    end

    always_comb
    begin
        mp_wide = 4'(mp_reg);
        pat_cur = mp_wide[3] ? 8'h00 : pat_arr[mp_wide[2:0]];
        mp_sum  = (MPW+1)'(mp_reg) + (MPW+1)'(1);
        mp_next = mp_reg;
        ep_next = ep_reg;
        ep_idx  = (ep_reg < 3'(ERR_LEN)) ? ep_reg : 3'd0;
        ep_sum  = 4'(ep_reg) + 4'd1;
        track   = '0;

        // Pattern tracker: advance, fall back to one on a first-byte hit, else drop
        if (rx_byte == pat_cur)
            mp_next = MPW'(mp_sum);
        else if (rx_byte == pat_arr[0])
            mp_next = MPW'(1);
        else
            mp_next = '0;

        if (rx_byte == ERR_TEXT[ep_idx])
            ep_next = 3'(ep_sum);
        else if (rx_byte == ERR_TEXT[0])
            ep_next = 3'd1;
        else
            ep_next = 3'd0;

        track.matched = (rx_byte == pat_cur) ? (5'(mp_sum) >= 5'(eff_len))
                                             : (5'(mp_next) >= 5'(eff_len));
        track.errored = (rx_byte == ERR_TEXT[ep_idx]) && (ep_sum >= 4'(ERR_LEN));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mp_reg <= '0;
            ep_reg <= '0;
        end
        else if (step)
        begin
            if (cmd == CMD_START)
            begin
                mp_reg <= '0;
                ep_reg <= '0;
            end
            else if (cmd == CMD_BYTE && phase == PH_MATCH)
            begin
                mp_reg <= mp_next;
                ep_reg <= ep_next;
            end
        end
    end

endmodule

@@ hw/rtl/rpw_seq.sv @@
`include "response_pattern_watcher_core_assert.svh"

module rpw_seq #(
    parameter int unsigned MAX_CAPTURE = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  rpw_pkg::cmd_t                     cmd,
    input  logic [7:0]                        rx_byte,
    input  rpw_pkg::track_t                   track,
    input  logic [rpw_pkg::TIMEOUT_W-1:0]     timeout_ticks,
    input  logic [rpw_pkg::CAPLEN_W-1:0]      capture_length,
    output rpw_pkg::phase_t                   phase,
    output rpw_pkg::result_t                  res
);
    import rpw_pkg::*;

    localparam int unsigned CAP_LIM = (MAX_CAPTURE < CAPLEN_MAX) ? MAX_CAPTURE : CAPLEN_MAX;
    localparam int unsigned CW      = $clog2(CAP_LIM + 1);

    phase_t               phase_reg, phase_next;
    logic [TIMEOUT_W-1:0] ticks_reg, ticks_next, ticks_inc;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW:0]          count_inc;
    logic                 success_reg, success_next;
    logic [CW-1:0]        eff_cap;

    assign phase = phase_reg;

    always_comb
    begin
        if (capture_length > CAPLEN_W'(CAP_LIM))
            eff_cap = CW'(CAP_LIM);
        else
            eff_cap = CW'(capture_length);
    end

    always_comb
    begin
        phase_next   = phase_reg;
        ticks_next   = ticks_reg;
        count_next   = count_reg;
        success_next = success_reg;
        res          = '0;
        ticks_inc    = (ticks_reg == '1) ? ticks_reg : ticks_reg + TIMEOUT_W'(1);
        count_inc    = (CW+1)'(count_reg) + (CW+1)'(1);

        case (cmd)
            CMD_START:
            begin
                phase_next   = PH_MATCH;
                ticks_next   = '0;
                count_next   = '0;
                success_next = 1'b1;
            end
            CMD_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    ticks_next = ticks_inc;
                    if (timeout_ticks != '0 && ticks_inc >= timeout_ticks)
                    begin
                        if (phase_reg == PH_CAPTURE && success_reg)
                            res.result_value = 11'(count_reg);
                        success_next = 1'b0;
                        res.done_res = 1'b1;
                        res.end_cause = CAUSE_TIMEOUT;
                        phase_next = PH_IDLE;
                    end
                end
            end
            CMD_BYTE:
            begin
                if (phase_reg == PH_MATCH)
                begin
                    if (track.errored || track.matched)
                    begin
                        if (track.errored)
                            success_next = 1'b0;
                        if (eff_cap == '0)
                        begin
                            res.done_res = 1'b1;
                            res.result_value = 11'(track.errored ? 1'b0 : success_reg);
                            res.end_cause = track.errored ? CAUSE_ERROR : CAUSE_MATCHED;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_CAPTURE;
                            count_next = '0;
                        end
                    end
                end
                else if (phase_reg == PH_CAPTURE)
                begin
                    res.data_valid = 1'b1;
                    res.data_byte  = rx_byte;
                    res.data_index = 10'(count_reg);
                    count_next     = CW'(count_inc);
                    if (count_inc >= (CW+1)'(eff_cap))
                    begin
                        res.done_res = 1'b1;
                        res.result_value = 11'(success_reg);
                        res.end_cause = CAUSE_FULL;
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            ticks_reg   <= '0;
            count_reg   <= '0;
            success_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            ticks_reg   <= ticks_next;
            count_reg   <= count_next;
            success_reg <= success_next;
        end
    end

    `RPW_ASSERT_NEXT(a_done_goes_idle, step && res.done_res, phase_reg == PH_IDLE, "done without idle")
    `RPW_ASSERT_NOW(a_capture_only, res.data_valid, phase_reg == PH_CAPTURE && cmd == CMD_BYTE, "stray capture")
    `RPW_ASSERT_NOW(a_idle_quiet, phase_reg == PH_IDLE && cmd != CMD_START, !res.data_valid && !res.done_res, "idle result not empty")

endmodule

@@ hw/rtl/response_pattern_watcher_core.sv @@
// Channel   | Group              | Contents (lowest bit first)
// ----------+--------------------+------------------------------------------------------
// request   | s_tvalid/s_tready  | s_tuser: command[1:0]; s_tdata: rx_byte[7:0]
// result    | m_tvalid/m_tready  | m_tuser: data_valid, done_res;
//           |                    | m_tdata: data_byte, data_index, result_value, end_cause
// config    | cfg_wr_en          | cfg_index selects register, cfg_data carries value
//
// One request is taken every cycle while s_tready is high; the request passes through
// the input register, its result is loaded into the result register and offered on
// m_tvalid, one result per request.
// The path between the two registers is the byte compares of both trackers and the
// tick, capture count and phase updates.
// Reset clears the trackers, phase and counters and loads the register defaults.
// A stalled result register holds its result; the input register still takes one
// more request, and s_tready drops only when both stages are full and m_tready is low.
`include "response_pattern_watcher_core_assert.svh"

module response_pattern_watcher_core #(
    parameter int unsigned MAX_PATTERN = 8,
    parameter int unsigned MAX_CAPTURE = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // rx_byte[7:0]
    input  logic [1:0]                         s_tuser,   // command[1:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,   // data_byte[7:0], data_index[17:8],
                                                          // result_value[28:18], end_cause[31:29]
    output logic [1:0]                         m_tuser,   // data_valid[0], done_res[1]
    input  logic                               cfg_wr_en,
    input  logic [1:0]                         cfg_index,
    input  logic [rpw_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rpw_pkg::*;

    // Configuration registers
    logic [PATTERN_W-1:0] pattern_reg;
    logic [PLEN_W-1:0]    plen_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [CAPLEN_W-1:0]  caplen_reg;

    // Input stage
    logic       in_valid_reg, in_valid_next;
    cmd_t       cmd_reg;
    logic [7:0] byte_reg;

    // Result stage
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    logic    advance;
    logic    step;
    logic    s_take;
    phase_t  phase;
    track_t  track;
    result_t res;

    // Move the held request on whenever the result register is free or draining
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    assign in_valid_next  = s_take || (in_valid_reg && !advance);
    assign out_valid_next = step || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= PATTERN_RESET;
            plen_reg    <= PLEN_RESET;
            timeout_reg <= '0;
            caplen_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PATTERN_BYTES:  pattern_reg <= cfg_data[PATTERN_W-1:0];
                CFG_PATTERN_LENGTH: plen_reg    <= cfg_data[PLEN_W-1:0];
                CFG_TIMEOUT_TICKS:  timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                CFG_CAPTURE_LENGTH: caplen_reg  <= cfg_data[CAPLEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: no reset; the input register loads on a handshake, the result register on a step
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            cmd_reg  <= cmd_t'(s_tuser);
            byte_reg <= s_tdata;
        end
        if (step)
        begin
            out_reg <= res;
        end
    end

    rpw_tracker #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .cmd            (cmd_reg),
        .rx_byte        (byte_reg),
        .phase          (phase),
        .pattern_bytes  (pattern_reg),
        .pattern_length (plen_reg),
        .track          (track)
    );

    rpw_seq #(
        .MAX_CAPTURE (MAX_CAPTURE)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .cmd            (cmd_reg),
        .rx_byte        (byte_reg),
        .track          (track),
        .timeout_ticks  (timeout_reg),
        .capture_length (caplen_reg),
        .phase          (phase),
        .res            (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.end_cause, out_reg.result_value,
                       out_reg.data_index, out_reg.data_byte};
    assign m_tuser  = {out_reg.done_res, out_reg.data_valid};

    `RPW_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, s_tready, "stall with empty result stage")
    `RPW_ASSERT_NEXT(a_hold_request, in_valid_reg && !advance, in_valid_reg, "held request lost")
    `RPW_ASSERT_NOW(a_full_cause, out_valid_reg && out_reg.data_valid && out_reg.done_res, out_reg.end_cause == CAUSE_FULL, "capture ended with wrong cause")

endmodule

@@ tb/tb_response_pattern_watcher_core.sv @@
module tb_response_pattern_watcher_core;

    import rpw_pkg::*;

    // One request as the sender offers it on the slave-side group
    typedef struct {
        cmd_t       cmd;
        logic [7:0] rx;
    } rx_request_t;

    // The fixed alarm text; the first character sits in the top byte of the literal
    localparam logic [39:0] ALARM_TEXT = "ERROR";
    localparam int unsigned ALARM_LEN  = 5;
    localparam int unsigned HOLD_LEN   = 80;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'h00;   // rx_byte[7:0]
    logic [1:0]            s_tuser   = CMD_NONE; // command[1:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;   // data_byte, data_index, result_value, end_cause
    logic [1:0]            m_tuser;   // data_valid, done_res
    logic                  cfg_wr_en = 1'b0;
    logic [1:0]            cfg_index = CFG_PATTERN_BYTES;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    response_pattern_watcher_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Shadow of the register file, kept in step with every write
    logic [63:0]      cfg_pattern = PATTERN_RESET;
    logic [3:0]       cfg_plen    = PLEN_RESET;
    logic [31:0]      cfg_timeout = '0;
    logic [10:0]      cfg_caplen  = '0;

    // Watcher state as the block should hold it
    phase_t           watch_phase   = PH_IDLE;
    int unsigned      pat_pos       = 0;
    int unsigned      alarm_pos     = 0;
    logic [31:0]      tick_count    = '0;
    int unsigned      capture_count = 0;
    logic             success       = 1'b1;

    rx_request_t      rx_requests[$];
    result_t          watch_results_due[$];

    logic             req_taken = 1'b0;
    int               burst_left = 0;
    int               gap_left = 0;
    int               hold_left = 0;
    int               stall_mode = 0;
    int               stall_left = 0;
    int               hold_requests = 0;
    int               holds_done = 0;
    int               long_holds = 0;

    int               accepted_reqs = 0;
    int               results_checked = 0;
    int               captured_seen = 0;
    int               mismatches = 0;
    int               stray_results = 0;
    int               reg_writes = 0;
    int               end_counts[8];
    result_t          seen;
    result_t          due;

    function automatic logic [7:0] alarm_char(input int unsigned k);
        return ALARM_TEXT[39 - 8 * k -: 8];
    endfunction

    function automatic logic [7:0] pattern_char(input int unsigned k);
        return (k < 8) ? cfg_pattern[8 * k +: 8] : 8'h00;
    endfunction

    // Pattern length in use: zero counts as one, anything above eight as eight
    function automatic int unsigned pattern_span();
        if (cfg_plen == 0)
            return 1;
        return (cfg_plen > 8) ? 8 : cfg_plen;
    endfunction

    function automatic void end_wait(inout result_t r, input int unsigned value,
                                     input cause_t cause);
        r.done_res     = 1'b1;
        r.result_value = value[10:0];
        r.end_cause    = cause;
        watch_phase    = PH_IDLE;
    endfunction

    // Advance the watcher by one accepted request and return the result it owes
    function automatic result_t watch_response(input cmd_t cmd, input logic [7:0] rx);
        result_t     r;
        int unsigned cap_span;
        int unsigned alarm_idx;
        logic        hit_pattern;
        logic        hit_alarm;
        r = '0;
        cap_span = (cfg_caplen > 1024) ? 1024 : cfg_caplen;
        hit_alarm = 1'b0;
        if (cmd == CMD_START)
        begin
            watch_phase   = PH_MATCH;
            pat_pos       = 0;
            alarm_pos     = 0;
            tick_count    = '0;
            capture_count = 0;
            success       = 1'b1;
        end
        else if (cmd == CMD_TICK && watch_phase != PH_IDLE)
        begin
            if (tick_count != 32'hFFFF_FFFF)
                tick_count++;
            if (cfg_timeout != 0 && tick_count >= cfg_timeout)
            begin
                // only a capture that follows a success reports its count
                end_wait(r, (watch_phase == PH_CAPTURE && success) ? capture_count : 0,
                         CAUSE_TIMEOUT);
                success = 1'b0;
            end
        end
        else if (cmd == CMD_BYTE && watch_phase == PH_MATCH)
        begin
            if (rx == pattern_char(pat_pos))
                pat_pos++;
            else if (rx == pattern_char(0))
                pat_pos = 1;
            else
                pat_pos = 0;
            hit_pattern = (pat_pos >= pattern_span());

            alarm_idx = (alarm_pos < ALARM_LEN) ? alarm_pos : 0;
            if (rx == alarm_char(alarm_idx))
            begin
                alarm_pos++;
                hit_alarm = (alarm_pos >= ALARM_LEN);
            end
            else if (rx == alarm_char(0))
                alarm_pos = 1;
            else
                alarm_pos = 0;

            // the alarm text wins when both complete on the same byte
            if (hit_alarm || hit_pattern)
            begin
                if (hit_alarm)
                    success = 1'b0;
                if (cap_span == 0)
                    end_wait(r, 32'(success), hit_alarm ? CAUSE_ERROR : CAUSE_MATCHED);
                else
                begin
                    watch_phase   = PH_CAPTURE;
                    capture_count = 0;
                end
            end
        end
        else if (cmd == CMD_BYTE && watch_phase == PH_CAPTURE)
        begin
            r.data_valid = 1'b1;
            r.data_byte  = rx;
            r.data_index = capture_count[9:0];
            capture_count++;
            if (capture_count >= cap_span)
                end_wait(r, 32'(success), CAUSE_FULL);
        end
        return r;
    endfunction

    // Sender: present the head of the request queue in bursts with gaps between
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || req_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (rx_requests.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= rx_requests[0].cmd;
                s_tdata  <= rx_requests[0].rx;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Accept side: drop the request from the queue and advance the watcher
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                void'(rx_requests.pop_front());
                watch_results_due.push_back(watch_response(cmd_t'(s_tuser), s_tdata));
                accepted_reqs++;
            end
        end
    end

    // Receiver: switch between stall patterns, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (holds_done < hold_requests)
        begin
            holds_done++;
            long_holds++;
            hold_left = HOLD_LEN;
            m_tready <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(10, 80);
                if ($urandom_range(0, 19) == 0)
                begin
                    long_holds++;
                    hold_left = $urandom_range(30, 60);
                end
            end
            stall_left--;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: check each result against the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.data_valid   = m_tuser[0];
            seen.done_res     = m_tuser[1];
            seen.data_byte    = m_tdata[7:0];
            seen.data_index   = m_tdata[17:8];
            seen.result_value = m_tdata[28:18];
            seen.end_cause    = cause_t'(m_tdata[31:29]);
            if (watch_results_due.size() == 0)
            begin
                stray_results++;
                if (stray_results + mismatches <= 10)
                    $display("result with no request owing it: tuser=%b tdata=%h",
                             m_tuser, m_tdata);
            end
            else
            begin
                due = watch_results_due.pop_front();
                results_checked++;
                if (due.done_res)
                    end_counts[due.end_cause]++;
                if (due.data_valid)
                    captured_seen++;
                if (seen.data_valid !== due.data_valid || seen.data_byte !== due.data_byte
                    || seen.data_index !== due.data_index || seen.done_res !== due.done_res
                    || seen.result_value !== due.result_value
                    || seen.end_cause !== due.end_cause)
                begin
                    mismatches++;
                    if (stray_results + mismatches <= 10)
                    begin
                        $display("result %0d: want dv=%b byte=%h idx=%0d done=%b val=%0d %s",
                                 results_checked, due.data_valid, due.data_byte,
                                 due.data_index, due.done_res, due.result_value,
                                 $sformatf("cause=%0d", due.end_cause));
                        $display("    got dv=%b byte=%h idx=%0d done=%b val=%0d cause=%0d",
                                 seen.data_valid, seen.data_byte, seen.data_index,
                                 seen.done_res, seen.result_value, seen.end_cause);
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_PATTERN_BYTES:  cfg_pattern = value;
            CFG_PATTERN_LENGTH: cfg_plen    = value[3:0];
            CFG_TIMEOUT_TICKS:  cfg_timeout = value[31:0];
            default:            cfg_caplen  = value[10:0];
        endcase
    endtask

    task automatic push_req(input cmd_t cmd, input logic [7:0] rx);
        rx_request_t item;
        item.cmd = cmd;
        item.rx  = rx;
        rx_requests.push_back(item);
    endtask

    task automatic push_bytes(input string text);
        foreach (text[k])
            push_req(CMD_BYTE, text[k]);
    endtask

    // Hold until every request is taken and every result is back
    task automatic wait_idle();
        while (rx_requests.size() != 0 || watch_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Favour bytes that move the trackers
    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 2);
        if (sel == 0)
            return pattern_char($urandom_range(0, 7));
        if (sel == 1)
            return alarm_char($urandom_range(0, ALARM_LEN - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [63:0] pick_pattern();
        logic [63:0] p;
        case ($urandom_range(0, 9))
            0:       p = '0;
            1:       p = '1;
            default:
                for (int k = 0; k < 8; k++)
                    p[8 * k +: 8] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                    : alarm_char($urandom_range(0, ALARM_LEN - 1));
        endcase
        return p;
    endfunction

    initial
    begin
        int random_reqs;
        int phase_len;
        int sel;
        int span;
        random_reqs = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: ignored requests while idle, then a match on the default
        // pattern and a plain error text
        push_req(CMD_BYTE, 8'hA5);
        push_req(CMD_NONE, 8'hFF);
        push_req(CMD_START, 8'h00);
        push_bytes("OK=");
        push_req(CMD_START, 8'hFF);
        push_bytes("ERROR");
        wait_idle();

        // Pattern equal to the error text: both trackers finish together, then
        // capture follows the error and ends full with a zero value
        write_reg(CFG_PATTERN_BYTES, 64'h0000_0052_4F52_5245);
        write_reg(CFG_PATTERN_LENGTH, 64'd5);
        write_reg(CFG_CAPTURE_LENGTH, 64'd2);
        @(posedge clk);
        push_req(CMD_START, 8'h00);
        push_bytes("ERROR");
        push_req(CMD_BYTE, 8'h00);
        push_req(CMD_BYTE, 8'hFF);
        wait_idle();

        // Length zero acts as one; timeout in the match phase, then timeout
        // during capture after a success
        write_reg(CFG_PATTERN_BYTES, '1);
        write_reg(CFG_PATTERN_LENGTH, 64'd0);
        write_reg(CFG_TIMEOUT_TICKS, 64'd3);
        write_reg(CFG_CAPTURE_LENGTH, 64'd5);
        @(posedge clk);
        push_req(CMD_START, 8'h00);
        repeat (3) push_req(CMD_TICK, 8'h00);
        push_req(CMD_START, 8'h00);
        push_req(CMD_BYTE, 8'hFF);
        push_req(CMD_BYTE, 8'h5A);
        repeat (3) push_req(CMD_TICK, 8'h00);
        wait_idle();

        // Random phases; ask the receiver for one long hold-off early on so the
        // pipeline fills and s_tready drops
        hold_requests++;
        while (random_reqs < 660)
        begin
            write_reg(CFG_PATTERN_BYTES, pick_pattern());
            write_reg(CFG_PATTERN_LENGTH, 64'($urandom_range(0, 15)));
            sel = $urandom_range(0, 9);
            write_reg(CFG_TIMEOUT_TICKS,
                      64'((sel < 4) ? 32'd0 : (sel < 8) ? $urandom_range(1, 12)
                          : (sel == 8) ? 32'hFFFF_FFFF : $urandom()));
            sel = $urandom_range(0, 19);
            write_reg(CFG_CAPTURE_LENGTH,
                      64'((sel < 8) ? 0 : (sel < 17) ? $urandom_range(1, 10)
                          : $urandom_range(11, 40)));
            @(posedge clk);
            // most phases start the wait; the rest continue or hit an idle block
            if ($urandom_range(0, 7) != 0)
                push_req(CMD_START, 8'($urandom_range(0, 255)));
            phase_len = $urandom_range(20, 60);
            for (int n = 0; n < phase_len; n++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 8)
                begin
                    span = pattern_span();
                    for (int k = 0; k < span; k++)
                        push_req(CMD_BYTE, pattern_char(k));
                end
                else if (sel < 12)
                begin
                    span = $urandom_range(1, ALARM_LEN);
                    for (int k = 0; k < span; k++)
                        push_req(CMD_BYTE, alarm_char(k));
                end
                else if (sel < 70)
                    push_req(CMD_BYTE, pick_byte());
                else if (sel < 85)
                    push_req(CMD_TICK, 8'($urandom_range(0, 255)));
                else if (sel < 90)
                    push_req(CMD_NONE, 8'($urandom_range(0, 255)));
                else if (sel < 95)
                    push_req(CMD_START, 8'($urandom_range(0, 255)));
                else
                    push_req(CMD_BYTE, 8'($urandom_range(0, 255)));
            end
            random_reqs += rx_requests.size();
            wait_idle();
        end

        // Capture length above the limit: capture runs on well past a short
        // window and a tick timeout ends it with the count taken after a success
        write_reg(CFG_PATTERN_BYTES, '0);
        write_reg(CFG_PATTERN_LENGTH, 64'd1);
        write_reg(CFG_TIMEOUT_TICKS, 64'd2);
        write_reg(CFG_CAPTURE_LENGTH, 64'd2047);
        @(posedge clk);
        push_req(CMD_START, 8'h00);
        push_req(CMD_BYTE, 8'h00);
        repeat (24) push_req(CMD_BYTE, 8'($urandom_range(0, 255)));
        repeat (2) push_req(CMD_TICK, 8'h00);
        push_req(CMD_BYTE, 8'h11);

        begin
            int drain;
            drain = 0;
            while ((rx_requests.size() != 0 || watch_results_due.size() != 0)
                   && drain < 50000)
            begin
                @(posedge clk);
                drain++;
            end
        end
        repeat (8) @(posedge clk);

        $display("%0d requests, %0d results checked, %0d captured bytes, %0d register writes",
                 accepted_reqs, results_checked, captured_seen, reg_writes);
        $display("waits ended: %0d matched, %0d error, %0d timeout, %0d full; %0d hold-offs",
                 end_counts[CAUSE_MATCHED], end_counts[CAUSE_ERROR],
                 end_counts[CAUSE_TIMEOUT], end_counts[CAUSE_FULL], long_holds);
        if (mismatches == 0 && stray_results == 0 && watch_results_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #(12 * 400000);
        $display("simulation failed");
        $finish;
    end

endmodule

@@ response_pattern_watcher_core.f @@
+incdir+hw/rtl
hw/rtl/rpw_pkg.sv
hw/rtl/rpw_tracker.sv
hw/rtl/rpw_seq.sv
hw/rtl/response_pattern_watcher_core.sv
tb/tb_response_pattern_watcher_core.sv
